// ===== rtl/core/sle_pkg.sv =====
`default_nettype none

package sle_pkg;

  // Action codes carried in the input transaction.
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;
  localparam logic [1:0] ACT_LIST   = 2'd3;

  typedef enum logic [2:0] {
    STAT_INSERTED    = 3'd0,
    STAT_FULL        = 3'd1,
    STAT_REMOVED     = 3'd2,
    STAT_NOT_FOUND   = 3'd3,
    STAT_EMPTY       = 3'd4,
    STAT_MATCH       = 3'd5,
    STAT_SEARCH_DONE = 3'd6,
    STAT_ENTRY       = 3'd7
  } status_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] operand_value;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [4:0]         entry_index;
    logic signed [31:0] entry_value;
    logic [5:0]         match_count;
    logic               last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_list_engine_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_item_t  (action, operand_value)
// out_      output     out_valid/out_ready  out_item_t (status, index, value,
//                                                       match_count, last)
//
// An item is accepted, then the entries it visits are read in turn through
// the single read port of the value store. Every action but list ends with
// a summary result; a list ends with its last entry. Single-result cases
// (full, empty) read no entry. A new item is taken only when the
// sequencer is idle, while the previous result may still sit in the output
// register. Synchronous reset clears the entry count; the store itself is not
// cleared. A stalled output freezes the walk through the store, reads included.

module sorted_list_engine_unit
  import sle_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire in_item_t  in_data,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      out_item_t out_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_LAST,
    S_REM,
    S_SRCH,
    S_LIST,
    S_REPLY
  } state_t;

  state_t             state_r, state_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   last_r, last_nxt;
  logic [IDX_W-1:0]   rp_r, rp_nxt;
  logic [IDX_W-1:0]   da_r, da_nxt;
  logic               rdone_r, rdone_nxt;
  logic               rv_r, rv_nxt;
  logic               found_r, found_nxt;
  status_t            status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic signed [31:0] ram_wdata;
  logic               ram_re;
  logic signed [31:0] ram_rdata;
  logic               out_free;
  logic               at_end;

  sle_ram #(
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The output register can take a new transaction this cycle.
  assign out_free = !out_valid_r || out_ready;
  // The entry now in the read data register is the last one to visit.
  assign at_end   = (state_r == S_INS) ? (da_r == '0) : (da_r == last_r);

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    count_nxt     = count_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    rp_nxt        = rp_r;
    da_nxt        = da_r;
    rdone_nxt     = rdone_r;
    rv_nxt        = rv_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = val_r;
    ram_re        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt   = in_data.operand_value;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          rv_nxt    = 1'b0;
          rdone_nxt = 1'b0;
          rp_nxt    = '0;
          last_nxt  = IDX_W'(count_r - 1'b1);
          if (in_data.action == ACT_INSERT) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              status_nxt = STAT_FULL;
              state_nxt  = S_REPLY;
            end else if (count_r == '0) begin
              state_nxt = S_INS_LAST;
            end else begin
              // Insert walks from the top entry downward.
              rp_nxt    = IDX_W'(count_r - 1'b1);
              state_nxt = S_INS;
            end
          end else if (count_r == '0) begin
            status_nxt = STAT_EMPTY;
            state_nxt  = S_REPLY;
          end else begin
            case (in_data.action)
              ACT_REMOVE: state_nxt = S_REM;
              ACT_SEARCH: state_nxt = S_SRCH;
              default:    state_nxt = S_LIST;
            endcase
          end
        end
      end

      S_INS, S_REM, S_SRCH, S_LIST: begin
        if (out_free) begin
          // Read issue stage: one entry per cycle while the output is free, one ahead of the data.
          rv_nxt = !rdone_r;
          if (!rdone_r) begin
            ram_re = 1'b1;
            da_nxt = rp_r;
            if (state_r == S_INS) begin
              rdone_nxt = (rp_r == '0);
              rp_nxt    = IDX_W'(rp_r - 1'b1);
            end else begin
              rdone_nxt = (rp_r == last_r);
              rp_nxt    = IDX_W'(rp_r + 1'b1);
            end
          end

          // Data stage: act on the entry now in the read data register.
          if (rv_r) begin
            case (state_r)
              S_INS: begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(da_r + 1'b1);
                if (ram_rdata > val_r) begin
                  // Larger entry moves up one place.
                  ram_wdata = ram_rdata;
                  if (at_end) begin
                    state_nxt = S_INS_LAST;
                  end
                end else begin
                  ram_wdata  = val_r;
                  count_nxt  = CNT_W'(count_r + 1'b1);
                  status_nxt = STAT_INSERTED;
                  state_nxt  = S_REPLY;
                end
              end
              S_REM: begin
                if (found_r) begin
                  // Close the gap left by the removed entry.
                  ram_we    = 1'b1;
                  ram_waddr = IDX_W'(da_r - 1'b1);
                  ram_wdata = ram_rdata;
                end else if (ram_rdata == val_r) begin
                  found_nxt = 1'b1;
                end
                if (at_end) begin
                  if (found_r || ram_rdata == val_r) begin
                    count_nxt  = CNT_W'(count_r - 1'b1);
                    status_nxt = STAT_REMOVED;
                  end else begin
                    status_nxt = STAT_NOT_FOUND;
                  end
                  state_nxt = S_REPLY;
                end
              end
              S_SRCH: begin
                if (ram_rdata == val_r) begin
                  out_valid_nxt            = 1'b1;
                  out_data_nxt.status      = STAT_MATCH;
                  out_data_nxt.entry_index = 5'(da_r);
                  out_data_nxt.entry_value = ram_rdata;
                  out_data_nxt.match_count = '0;
                  out_data_nxt.last        = 1'b0;
                  cnt_nxt                  = CNT_W'(cnt_r + 1'b1);
                end
                if (at_end) begin
                  status_nxt = STAT_SEARCH_DONE;
                  state_nxt  = S_REPLY;
                end
              end
              default: begin
                out_valid_nxt            = 1'b1;
                out_data_nxt.status      = STAT_ENTRY;
                out_data_nxt.entry_index = 5'(da_r);
                out_data_nxt.entry_value = ram_rdata;
                out_data_nxt.match_count = '0;
                out_data_nxt.last        = at_end;
                if (at_end) begin
                  state_nxt = S_IDLE;
                end
              end
            endcase
          end
        end
      end

      S_INS_LAST: begin
        // The new value goes to the bottom of the list.
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = val_r;
        count_nxt  = CNT_W'(count_r + 1'b1);
        status_nxt = STAT_INSERTED;
        state_nxt  = S_REPLY;
      end

      S_REPLY: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.entry_index = '0;
          out_data_nxt.entry_value = '0;
          out_data_nxt.match_count = 6'(cnt_r);
          out_data_nxt.last        = 1'b1;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rv_r        <= 1'b0;
      rdone_r     <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rv_r        <= rv_nxt;
      rdone_r     <= rdone_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    val_r      <= val_nxt;
    cnt_r      <= cnt_nxt;
    last_r     <= last_nxt;
    rp_r       <= rp_nxt;
    da_r       <= da_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // The entry count never exceeds the capacity of the store.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // The count moves by at most one per cycle.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_r)) ||
             (count_r == CNT_W'($past(count_r) + 1'b1)) ||
             (count_r == CNT_W'($past(count_r) - 1'b1)))
    else $error("entry count jumped");

  // A shift write never targets the entry being read in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != rp_r))
    else $error("read and write to the same store entry");

  // Match results are never the final result of a search.
  a_match_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == STAT_MATCH) |-> !out_data_r.last)
    else $error("match result marked last");

  // The sequencer changes the store only while working on an item.
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_INS || state_r == S_INS_LAST || state_r == S_REM))
    else $error("store written outside insert or remove");

endmodule

`default_nettype wire

// ===== rtl/core/sle_ram.sv =====
`default_nettype none

module sle_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire logic signed [31:0]  wdata,
  input  wire logic                re,
  input  wire logic [AW-1:0]       raddr,
  output      logic signed [31:0]  rdata
);

  logic signed [31:0] mem [DEPTH];

  // One write and one registered read per cycle. The read data holds
  // while no read is issued, which lets the sequencer stall freely.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sim/sorted_list_engine_unit_tb.sv =====
`default_nettype none

// Checks the sorted list engine against a behavioral copy of the list that
// is kept inside this bench. Each input transaction is applied to the local
// copy when it is accepted. The results it must cause go into a queue, and
// the checker compares each result transaction the block hands out with the
// oldest entry of that queue, field by field.

module sorted_list_engine_unit_tb;
  import sle_pkg::*;

  localparam int CAPACITY = 32;

  // The limit covers several hundred transactions. Each one can produce up
  // to CAPACITY+1 results, and both sides can stall.
  localparam int RUN_LIMIT = 3_000_000;

  // After the last result the bench keeps watching for stray results.
  localparam int TAIL_CYCLES = 60;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // When set, neither side inserts idle cycles.
  bit no_gaps = 1'b0;

  // This is the local copy of the list. Only entries below held_count carry
  // meaning.
  logic signed [31:0] sorted_vals [CAPACITY];
  int                 held_count  = 0;

  out_item_t pending_results [$];
  int        mismatch_count = 0;

  sorted_list_engine_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string detail);
    $display("MISMATCH at %0t: %s", $time, detail);
    mismatch_count++;
  endtask

  // Applies one accepted transaction to the local list. It queues every
  // result the transaction must produce, in order.
  function automatic void apply_list_action(input in_item_t item);
    out_item_t          res;
    int                 pos;
    int                 hits;
    logic signed [31:0] v;
    v   = item.operand_value;
    res = '0;
    res.last = 1'b1;
    if (item.action == ACT_INSERT) begin
      if (held_count >= CAPACITY) begin
        res.status = STAT_FULL;
      end else begin
        // The new value goes in front of the first strictly larger entry.
        // Equal entries therefore stay ahead of it.
        pos = 0;
        while (pos < held_count && sorted_vals[pos] <= v) pos++;
        for (int j = held_count; j > pos; j--) sorted_vals[j] = sorted_vals[j - 1];
        sorted_vals[pos] = v;
        held_count++;
        res.status = STAT_INSERTED;
      end
      pending_results.push_back(res);
    end else if (held_count == 0) begin
      res.status = STAT_EMPTY;
      pending_results.push_back(res);
    end else if (item.action == ACT_REMOVE) begin
      pos = 0;
      while (pos < held_count && sorted_vals[pos] != v) pos++;
      if (pos == held_count) begin
        res.status = STAT_NOT_FOUND;
      end else begin
        for (int j = pos; j + 1 < held_count; j++) sorted_vals[j] = sorted_vals[j + 1];
        held_count--;
        res.status = STAT_REMOVED;
      end
      pending_results.push_back(res);
    end else if (item.action == ACT_SEARCH) begin
      hits = 0;
      for (int i = 0; i < held_count; i++) begin
        if (sorted_vals[i] == v) begin
          res             = '0;
          res.status      = STAT_MATCH;
          res.entry_index = 5'(i);
          res.entry_value = sorted_vals[i];
          pending_results.push_back(res);
          hits++;
        end
      end
      res             = '0;
      res.status      = STAT_SEARCH_DONE;
      res.match_count = 6'(hits);
      res.last        = 1'b1;
      pending_results.push_back(res);
    end else begin
      for (int i = 0; i < held_count; i++) begin
        res             = '0;
        res.status      = STAT_ENTRY;
        res.entry_index = 5'(i);
        res.entry_value = sorted_vals[i];
        res.last        = (i + 1 == held_count);
        pending_results.push_back(res);
      end
    end
  endfunction

  // Presents one transaction and waits until the block takes it. Valid is
  // left high afterwards, so the next call can follow without a bubble.
  // Valid is lowered only when this call decides to idle first, and that
  // happens at an earlier time step than the next raise.
  task automatic send_item(input logic [1:0] act, input logic signed [31:0] val);
    in_item_t item;
    item.action        = act;
    item.operand_value = val;
    if (!no_gaps && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    apply_list_action(item);
  endtask

  // Lowers valid once the stimulus is done.
  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Removes every stored value, largest first, until the list is empty.
  task automatic drain_list();
    while (held_count > 0) send_item(ACT_REMOVE, sorted_vals[held_count - 1]);
  endtask

  // Picks an operand. Most picks come from a small pool of values near zero
  // and at the extremes, so duplicates and hits are common. When asked, the
  // pick usually reuses a value that is currently in the list.
  function automatic logic signed [31:0] pick_operand(input bit from_list);
    if (from_list && held_count > 0 && $urandom_range(99) < 70)
      return sorted_vals[$urandom_range(held_count - 1)];
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4, 5, 6: return int'($urandom_range(6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  // Remove, search and list on an empty list each report empty.
  task automatic test_empty_list();
    send_item(ACT_REMOVE, 32'sd5);
    send_item(ACT_SEARCH, 32'sd0);
    send_item(ACT_LIST, $urandom);
  endtask

  // This test covers both ends of the signed range, duplicate placement,
  // searches with several hits and with none, and remove hits and misses.
  task automatic test_value_extremes();
    send_item(ACT_INSERT, 32'sh7fff_ffff);
    send_item(ACT_INSERT, 32'sh8000_0000);
    send_item(ACT_INSERT, 32'sd0);
    send_item(ACT_INSERT, -32'sd1);
    send_item(ACT_INSERT, 32'sd1);
    send_item(ACT_INSERT, 32'sh8000_0000);
    send_item(ACT_LIST, $urandom);
    send_item(ACT_SEARCH, 32'sh8000_0000);
    send_item(ACT_SEARCH, 32'sd2);
    send_item(ACT_REMOVE, 32'sd12345);
    send_item(ACT_REMOVE, 32'sh8000_0000);
    send_item(ACT_LIST, $urandom);
    drain_list();
    send_item(ACT_REMOVE, -32'sd1);
  endtask

  // This test fills the store with a single value and then pushes one more.
  // A search for that value must then give the longest result burst of all,
  // CAPACITY matches and the summary. It runs with no idle cycles on either
  // side.
  task automatic test_full_list();
    logic signed [31:0] same;
    same    = $urandom;
    no_gaps = 1'b1;
    while (held_count < CAPACITY) send_item(ACT_INSERT, same);
    send_item(ACT_INSERT, ~same);
    send_item(ACT_SEARCH, same);
    send_item(ACT_SEARCH, ~same);
    send_item(ACT_LIST, $urandom);
    send_item(ACT_REMOVE, ~same);
    send_item(ACT_INSERT, same);
    drain_list();
    no_gaps = 1'b0;
  endtask

  // Random traffic swings the list between empty and full. While it grows,
  // inserts dominate. While it shrinks, removes dominate. Searches and lists
  // are mixed in all along. Part of the run has no idle cycles.
  task automatic test_random_traffic(input int item_total);
    bit         growing;
    int         roll;
    logic [1:0] act;
    growing = 1'b1;
    for (int k = 0; k < item_total; k++) begin
      no_gaps = (k >= item_total / 2 && k < item_total / 2 + 60);
      if (held_count >= CAPACITY)
        growing = 1'b0;
      else if (held_count == 0)
        growing = 1'b1;
      else if ($urandom_range(99) < 3)
        growing = !growing;
      roll = $urandom_range(99);
      if (roll < 55)
        act = growing ? ACT_INSERT : ACT_REMOVE;
      else if (roll < 68)
        act = growing ? ACT_REMOVE : ACT_INSERT;
      else if (roll < 84)
        act = ACT_SEARCH;
      else
        act = ACT_LIST;
      send_item(act, pick_operand(act != ACT_INSERT));
    end
    no_gaps = 1'b0;
  endtask

  // The result side stalls about 15 percent of the time, except during
  // the stretch with no idle cycles.
  always @(posedge clk) begin
    out_ready <= no_gaps || ($urandom_range(99) >= 15);
  end

  // Every accepted result must match the oldest queued one, field by field.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %p", out_data));
      end else begin
        want = pending_results.pop_front();
        if (out_data.status != want.status)
          report_mismatch($sformatf("status %s, wanted %s",
                                    out_data.status.name(), want.status.name()));
        if (out_data.entry_index != want.entry_index)
          report_mismatch($sformatf("entry_index %0d, wanted %0d",
                                    out_data.entry_index, want.entry_index));
        if (out_data.entry_value != want.entry_value)
          report_mismatch($sformatf("entry_value %0d, wanted %0d",
                                    out_data.entry_value, want.entry_value));
        if (out_data.match_count != want.match_count)
          report_mismatch($sformatf("match_count %0d, wanted %0d",
                                    out_data.match_count, want.match_count));
        if (out_data.last != want.last)
          report_mismatch($sformatf("last %0b, wanted %0b", out_data.last, want.last));
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_value_extremes();
    test_full_list();
    test_random_traffic(270);
    stop_sending();

    // Once nothing is pending, the bench keeps watching for stray results.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("TIMEOUT with %0d results still pending", pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
